[rtl/fqir_pkg.sv]
// Package with the command and status codes, the result type and default sizes of the queue.
package fqir_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W   = 2;
	localparam int WORD_W  = 32;
	localparam int POS_W   = 4;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ = 2'd0,
		CMD_DEQ = 2'd1,
		CMD_RD  = 2'd2,
		CMD_RM  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_RANGE = 3'd2,
		ST_NULL  = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef struct packed {
		status_t              status;
		logic [WORD_W-1:0]    data;
		logic [COUNT_W-1:0]   count;
	} result_t;

endpackage

[rtl/fqir_store.sv]
// Queue storage and count with the command decode, the read mux and the compacting shift.
module fqir_store
	import fqir_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                exec,
	input  cmd_t                cmd,
	input  logic [WORD_W-1:0]   word_in,
	input  logic [POS_W-1:0]    pos,
	output result_t             res
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int PW   = (CW > POS_W) ? CW : POS_W;
	localparam int RD_N = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

	logic [DATA_WIDTH-1:0] entries_q [DEPTH];
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [POS_W-1:0]      sel_pos;
	logic                  pos_ok;
	logic                  empty;
	logic                  full;
	logic                  do_enq;
	logic                  do_rm;

	assign word    = DATA_WIDTH'(word_in);
	assign sel_pos = (cmd == CMD_DEQ) ? '0 : pos;
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign pos_ok  = (PW'(sel_pos) < PW'(count_q));

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (sel_pos == POS_W'(i)) begin
				rd_word = entries_q[i];
			end
		end
	end

	always_comb begin
		res.status = ST_OK;
		res.data   = '0;
		do_enq     = 1'b0;
		do_rm      = 1'b0;
		case (cmd)
			CMD_ENQ: begin
				if (word == '0) begin
					res.status = ST_NULL;
				end else if (full) begin
					res.status = ST_FULL;
				end else begin
					do_enq = exec;
				end
			end
			CMD_DEQ, CMD_RD, CMD_RM: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else if (!pos_ok) begin
					res.status = ST_RANGE;
				end else begin
					res.data = WORD_W'(rd_word);
					do_rm    = exec && (cmd != CMD_RD);
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
		if (do_enq) begin
			count_d = count_q + CW'(1);
		end else if (do_rm) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
		res.count = COUNT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec) begin
			count_q <= count_d;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		if (i < DEPTH - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (do_enq && count_q == CW'(i)) begin
					entries_q[i] <= word;
				end else if (do_rm && PW'(i) >= PW'(sel_pos)) begin
					entries_q[i] <= entries_q[i+1];
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (do_enq && count_q == CW'(i)) begin
					entries_q[i] <= word;
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		exec && cmd == CMD_ENQ && res.status == ST_OK |=> count_q == $past(count_q) + CW'(1))
		else $error("accepted enqueue did not add one entry");

	a_take_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (cmd == CMD_DEQ || cmd == CMD_RM) && res.status == ST_OK
		|=> count_q == $past(count_q) - CW'(1))
		else $error("dequeue or remove did not drop one entry");

	a_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		exec && res.status != ST_OK |=> $stable(count_q))
		else $error("refused command changed the count");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.status != ST_OK |-> res.data == '0)
		else $error("error result carries a nonzero word");

endmodule

[rtl/fifo_queue_indexed_remove.sv]
// Top level of the queue with indexed read and remove: input stage, result stage and flow control.
//
// Input channel: command, data_in and position travel with in_valid; a word is taken at a
// rising edge where in_valid is high and in_stall is low. Commands are enqueue at the tail,
// dequeue from the head, read at a position counted from the head, and remove at a position,
// which closes the gap so later entries move one place toward the head.
// Output channel: each command returns exactly one word of status, data_out and entry_count
// with out_valid; it is taken at an edge where out_valid is high and out_stall is low.
// The accepted command sits in the input register, is executed against the queue state, and
// its result is held in the output register.
// Throughput is one command per cycle unless the receiver stalls; the queue update and the
// result are produced by one pass of decode, read mux and parallel shift over the register array.
// When the receiver stalls, the result register holds its word, the input register holds the
// pending command, and in_stall rises once that register is occupied.
// Reset clears the entry count and both valid flags; the queue comes up empty and the first
// command may be taken right after reset is released.
module fifo_queue_indexed_remove
	import fqir_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [WORD_W-1:0]    data_in,
	input  logic [POS_W-1:0]     position,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STAT_W-1:0]    status,
	output logic [WORD_W-1:0]    data_out,
	output logic [COUNT_W-1:0]   entry_count
);

	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [WORD_W-1:0]   data_s1;
	logic [POS_W-1:0]    pos_s1;
	logic                valid_s2;
	result_t             res_s2;
	result_t             res;
	logic                adv;
	logic                exec;

	assign adv      = !valid_s2 || !out_stall;
	assign exec     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd_t'(command);
			data_s1 <= data_in;
			pos_s1  <= position;
		end
		if (exec) begin
			res_s2 <= res;
		end
	end

	fqir_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.exec    (exec),
		.cmd     (cmd_s1),
		.word_in (data_s1),
		.pos     (pos_s1),
		.res     (res)
	);

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign data_out    = res_s2.data;
	assign entry_count = res_s2.count;

endmodule
